/* hdl/pfau_pkg.sv */
// ----------------------------------------------------------------------------
// pfau_pkg
// shared types and constants of the prime field arithmetic unit
// ----------------------------------------------------------------------------
package pfau_pkg;

  localparam int DATA_BITS     = 32;
  localparam int OP_BITS       = 4;
  localparam int WORD_BITS_DEF = 32;

  // request opcodes
  typedef enum logic [OP_BITS-1:0] {
    OP_REDUCE   = 4'd0,
    OP_ADD      = 4'd1,
    OP_SUB      = 4'd2,
    OP_MUL      = 4'd3,
    OP_MUL3     = 4'd4,
    OP_MULC     = 4'd5,
    OP_MULADD   = 4'd6,
    OP_SUBMULS  = 4'd7,
    OP_SUBDIV   = 4'd8,
    OP_INV      = 4'd9,
    OP_POW      = 4'd10,
    OP_TOSIGNED = 4'd11
  } op_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_MUL,
    ST_DIV
  } state_t;

  // step phases within one request
  typedef enum logic [3:0] {
    PC_0,
    PC_1,
    PC_2,
    PC_INV_INIT,
    PC_INV_TEST,
    PC_INV_QT,
    PC_INV_T,
    PC_SD_DIFF,
    PC_SD_END,
    PC_PW_FIND,
    PC_PW_LOOP,
    PC_PW_SQ,
    PC_PW_ML
  } pc_t;

  // what a step hands to the sequencer
  typedef enum logic [1:0] {
    ACT_STAY,
    ACT_MUL,
    ACT_DIV,
    ACT_DONE
  } act_t;

endpackage

/* hdl/pfau_req_if.sv */
// ----------------------------------------------------------------------------
// pfau_req_if
// request channel: opcode and four operands
// ----------------------------------------------------------------------------
interface pfau_req_if;
  logic                           valid;
  logic                           ready;
  logic [pfau_pkg::OP_BITS-1:0]   req_type;
  logic [pfau_pkg::DATA_BITS-1:0] operand_a;
  logic [pfau_pkg::DATA_BITS-1:0] operand_b;
  logic [pfau_pkg::DATA_BITS-1:0] operand_c;
  logic [pfau_pkg::DATA_BITS-1:0] operand_d;

  modport source (output valid, req_type, operand_a, operand_b, operand_c, operand_d,
                  input ready);
  modport sink (input valid, req_type, operand_a, operand_b, operand_c, operand_d,
                output ready);
endinterface

/* hdl/pfau_rsp_if.sv */
// ----------------------------------------------------------------------------
// pfau_rsp_if
// response channel: residue, signed value and error flag
// ----------------------------------------------------------------------------
interface pfau_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic        [pfau_pkg::DATA_BITS-1:0] result_value;
  logic signed [pfau_pkg::DATA_BITS-1:0] signed_value;
  logic                                  error_flag;

  modport source (output valid, result_value, signed_value, error_flag, input ready);
  modport sink (input valid, result_value, signed_value, error_flag, output ready);
endinterface

/* hdl/prime_field_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// prime_field_arithmetic_unit
// modular arithmetic over a configured prime, one shared multiplier and
// one shared restoring divider under a small step sequencer
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake    | beat contents
//  --------+-----+--------------+------------------------------------------
//  req     | in  | valid/ready  | req_type, operand_a..operand_d
//  rsp     | out | valid/ready  | result_value, signed_value, error_flag
//  cfg     | in  | cfg_we       | cfg_wdata: prime modulus
//
//  add, sub, to_signed and error cases finish in a single step; every modular
//  multiply or reduction makes one pass through the shared divider, pow takes
//  up to 2*WORD_BITS-2 multiplies, inverse two divider passes per euclid
//  step.
//  rst clears the sequencer, the response slot and sets the modulus to 2.
//  req.ready is high only while the sequencer is idle; a finished result sits
//  in the response register, so a new request is taken while it waits, and
//  the sequencer holds its last step if the slot is still full.
//
module prime_field_arithmetic_unit #(
  parameter int WORD_BITS = pfau_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pfau_pkg::DATA_BITS-1:0] cfg_wdata,
  pfau_req_if.sink                       req,
  pfau_rsp_if.source                     rsp
);

  localparam int W   = WORD_BITS;
  localparam int CW  = $clog2(W);
  localparam int DCW = $clog2(2 * W);
  localparam int DB  = pfau_pkg::DATA_BITS;

  // modulus register
  logic [DB-1:0] prime;

  // sequencer
  pfau_pkg::state_t state, state_next;
  pfau_pkg::pc_t    pc, pc_next;
  pfau_pkg::act_t   act;
  logic [pfau_pkg::OP_BITS-1:0] op, op_next;

  // operand and working registers
  logic [W-1:0] a, a_next, b, b_next, c, c_next, d, d_next;
  logic [W-1:0] x, x_next, acc, acc_next, n, n_next;
  logic [W-1:0] r0, r0_next, r1, r1_next, t0, t0_next, t1, t1_next;
  logic [CW-1:0] cnt, cnt_next;

  // shared multiplier operands and divider
  logic [W-1:0]   mx, mx_next, my, my_next;
  logic [2*W-1:0] dnum, dnum_next;
  logic [W-1:0]   drem, drem_next, dden, dden_next;
  logic [DCW-1:0] dcnt, dcnt_next;
  logic [W:0]     dtrial;
  logic           dge;

  // response slot
  logic                 out_valid, out_valid_next;
  logic [DB-1:0]        res_q, res_next;
  logic signed [DB-1:0] sres_q, sres_next;
  logic                 err_q, err_next;
  logic                 slot_free;

  // finish request from a step
  logic                 done_req;
  logic [W-1:0]         done_res;
  logic signed [DB-1:0] done_sres;
  logic                 done_err;

  logic [W-1:0] p;
  logic [W-1:0] half_p;
  logic [W-1:0] q;

  assign p         = prime[W-1:0];
  assign half_p    = (p - W'(1)) >> 1;
  assign q         = dnum[W-1:0];
  assign slot_free = !out_valid || rsp.ready;

  // x - y with one correction by p, wrapping to the word
  function automatic logic [W-1:0] sub_mod(logic [W-1:0] sx, logic [W-1:0] sy,
                                           logic [W-1:0] sp);
    if (sx < sy) begin
      return sp - sy + sx;
    end
    return sx - sy;
  endfunction

  // x + y with one correction by p, wrapping to the word
  function automatic logic [W-1:0] add_mod(logic [W-1:0] ax, logic [W-1:0] ay,
                                           logic [W-1:0] ap);
    logic [W:0] s;
    s = {1'b0, ax} + {1'b0, ay};
    if (s < {1'b0, ap}) begin
      return s[W-1:0];
    end
    return W'(s - {1'b0, ap});
  endfunction

  // divider step: shift one dividend bit into the remainder
  assign dtrial = {drem, dnum[2*W-1]};
  assign dge    = dtrial >= {1'b0, dden};

  // datapath and step decode
  always_comb begin
    op_next        = op;
    pc_next        = pc;
    a_next         = a;
    b_next         = b;
    c_next         = c;
    d_next         = d;
    x_next         = x;
    acc_next       = acc;
    n_next         = n;
    r0_next        = r0;
    r1_next        = r1;
    t0_next        = t0;
    t1_next        = t1;
    cnt_next       = cnt;
    mx_next        = mx;
    my_next        = my;
    dnum_next      = dnum;
    drem_next      = drem;
    dden_next      = dden;
    dcnt_next      = dcnt;
    res_next       = res_q;
    sres_next      = sres_q;
    err_next       = err_q;
    out_valid_next = out_valid && !rsp.ready;
    act            = pfau_pkg::ACT_STAY;
    done_req       = 1'b0;
    done_res       = '0;
    done_sres      = '0;
    done_err       = 1'b0;

    unique case (state)
      pfau_pkg::ST_IDLE: begin
        if (req.valid) begin
          op_next = req.req_type;
          a_next  = req.operand_a[W-1:0];
          b_next  = req.operand_b[W-1:0];
          c_next  = req.operand_c[W-1:0];
          d_next  = req.operand_d[W-1:0];
          pc_next = pfau_pkg::PC_0;
        end
      end

      pfau_pkg::ST_STEP: begin
        if (pc == pfau_pkg::PC_0 && p < W'(2)) begin
          // modulus below two
          done_req = 1'b1;
          done_err = 1'b1;
        end else begin
          case (op)
            pfau_pkg::OP_REDUCE: begin
              if (pc == pfau_pkg::PC_0) begin
                act       = pfau_pkg::ACT_DIV;
                dnum_next = {{W{1'b0}}, a};
                dden_next = p;
                pc_next   = pfau_pkg::PC_1;
              end else begin
                done_req = 1'b1;
                done_res = drem;
              end
            end
            pfau_pkg::OP_ADD: begin
              done_req = 1'b1;
              done_res = add_mod(a, b, p);
            end
            pfau_pkg::OP_SUB: begin
              done_req = 1'b1;
              done_res = sub_mod(a, b, p);
            end
            pfau_pkg::OP_MUL, pfau_pkg::OP_MULC: begin
              if (pc == pfau_pkg::PC_0) begin
                act     = pfau_pkg::ACT_MUL;
                mx_next = a;
                my_next = b;
                pc_next = pfau_pkg::PC_1;
              end else begin
                done_req = 1'b1;
                done_res = drem;
              end
            end
            pfau_pkg::OP_MUL3: begin
              if (pc == pfau_pkg::PC_0) begin
                act     = pfau_pkg::ACT_MUL;
                mx_next = a;
                my_next = b;
                pc_next = pfau_pkg::PC_1;
              end else if (pc == pfau_pkg::PC_1) begin
                act     = pfau_pkg::ACT_MUL;
                mx_next = drem;
                my_next = c;
                pc_next = pfau_pkg::PC_2;
              end else begin
                done_req = 1'b1;
                done_res = drem;
              end
            end
            pfau_pkg::OP_MULADD: begin
              if (pc == pfau_pkg::PC_0) begin
                act     = pfau_pkg::ACT_MUL;
                mx_next = a;
                my_next = b;
                pc_next = pfau_pkg::PC_1;
              end else if (pc == pfau_pkg::PC_1) begin
                act       = pfau_pkg::ACT_DIV;
                x_next    = drem;
                dnum_next = {{W{1'b0}}, c};
                dden_next = p;
                pc_next   = pfau_pkg::PC_2;
              end else begin
                done_req = 1'b1;
                done_res = add_mod(x, drem, p);
              end
            end
            pfau_pkg::OP_SUBMULS: begin
              if (pc == pfau_pkg::PC_0) begin
                act     = pfau_pkg::ACT_MUL;
                mx_next = a;
                my_next = b;
                pc_next = pfau_pkg::PC_1;
              end else if (pc == pfau_pkg::PC_1) begin
                act     = pfau_pkg::ACT_MUL;
                x_next  = drem;
                mx_next = c;
                my_next = d;
                pc_next = pfau_pkg::PC_2;
              end else begin
                done_req = 1'b1;
                done_res = sub_mod(x, drem, p);
              end
            end
            pfau_pkg::OP_INV, pfau_pkg::OP_SUBDIV: begin
              unique case (pc)
                pfau_pkg::PC_0: begin
                  // reduce the value to invert
                  act       = pfau_pkg::ACT_DIV;
                  dnum_next = {{W{1'b0}}, (op == pfau_pkg::OP_INV) ? a : c};
                  dden_next = p;
                  pc_next   = pfau_pkg::PC_INV_INIT;
                end
                pfau_pkg::PC_INV_INIT: begin
                  if (drem == '0) begin
                    done_req = 1'b1;
                    done_err = 1'b1;
                  end else begin
                    r0_next = p;
                    r1_next = drem;
                    t0_next = '0;
                    t1_next = W'(1);
                    pc_next = pfau_pkg::PC_INV_TEST;
                  end
                end
                pfau_pkg::PC_INV_TEST: begin
                  if (r1 == '0) begin
                    if (op == pfau_pkg::OP_INV) begin
                      done_req = 1'b1;
                      done_res = t0;
                    end else begin
                      act       = pfau_pkg::ACT_DIV;
                      x_next    = t0;
                      dnum_next = {{W{1'b0}}, a};
                      dden_next = p;
                      pc_next   = pfau_pkg::PC_SD_DIFF;
                    end
                  end else begin
                    act       = pfau_pkg::ACT_DIV;
                    dnum_next = {{W{1'b0}}, r0};
                    dden_next = r1;
                    pc_next   = pfau_pkg::PC_INV_QT;
                  end
                end
                pfau_pkg::PC_INV_QT: begin
                  // quotient times t1, reduced by p
                  act     = pfau_pkg::ACT_MUL;
                  r0_next = r1;
                  r1_next = drem;
                  mx_next = q;
                  my_next = t1;
                  pc_next = pfau_pkg::PC_INV_T;
                end
                pfau_pkg::PC_INV_T: begin
                  t0_next = t1;
                  t1_next = sub_mod(t0, drem, p);
                  pc_next = pfau_pkg::PC_INV_TEST;
                end
                pfau_pkg::PC_SD_DIFF: begin
                  act     = pfau_pkg::ACT_MUL;
                  mx_next = sub_mod(drem, b, p);
                  my_next = x;
                  pc_next = pfau_pkg::PC_SD_END;
                end
                default: begin
                  done_req = 1'b1;
                  done_res = drem;
                end
              endcase
            end
            pfau_pkg::OP_POW: begin
              unique case (pc)
                pfau_pkg::PC_0: begin
                  if (b == '0) begin
                    done_req = 1'b1;
                    done_res = W'(1);
                  end else begin
                    n_next   = b;
                    cnt_next = CW'(W - 1);
                    pc_next  = pfau_pkg::PC_PW_FIND;
                  end
                end
                pfau_pkg::PC_PW_FIND: begin
                  // shift up to the leading one, then drop it
                  n_next = n << 1;
                  if (n[W-1]) begin
                    acc_next = a;
                    pc_next  = pfau_pkg::PC_PW_LOOP;
                  end else begin
                    cnt_next = cnt - CW'(1);
                  end
                end
                pfau_pkg::PC_PW_LOOP: begin
                  if (cnt == '0) begin
                    done_req = 1'b1;
                    done_res = acc;
                  end else begin
                    act     = pfau_pkg::ACT_MUL;
                    mx_next = acc;
                    my_next = acc;
                    pc_next = pfau_pkg::PC_PW_SQ;
                  end
                end
                pfau_pkg::PC_PW_SQ: begin
                  acc_next = drem;
                  if (n[W-1]) begin
                    act     = pfau_pkg::ACT_MUL;
                    mx_next = drem;
                    my_next = a;
                    pc_next = pfau_pkg::PC_PW_ML;
                  end else begin
                    n_next   = n << 1;
                    cnt_next = cnt - CW'(1);
                    pc_next  = pfau_pkg::PC_PW_LOOP;
                  end
                end
                default: begin
                  acc_next = drem;
                  n_next   = n << 1;
                  cnt_next = cnt - CW'(1);
                  pc_next  = pfau_pkg::PC_PW_LOOP;
                end
              endcase
            end
            pfau_pkg::OP_TOSIGNED: begin
              done_req = 1'b1;
              if (a > half_p) begin
                done_sres = DB'(a) - DB'(p);
              end else begin
                done_sres = DB'(a);
              end
            end
            default: begin
              done_req = 1'b1;
              done_err = 1'b1;
            end
          endcase
        end

        if (done_req) begin
          if (slot_free) begin
            act            = pfau_pkg::ACT_DONE;
            res_next       = DB'(done_res);
            sres_next      = done_sres;
            err_next       = done_err;
            out_valid_next = 1'b1;
          end
        end

        if (act == pfau_pkg::ACT_DIV) begin
          drem_next = '0;
          dcnt_next = '0;
        end
      end

      pfau_pkg::ST_MUL: begin
        // one registered product, then reduce it by p
        dnum_next = (2*W)'(mx) * (2*W)'(my);
        dden_next = p;
        drem_next = '0;
        dcnt_next = '0;
      end

      pfau_pkg::ST_DIV: begin
        // restoring division, one quotient bit a cycle
        dnum_next = {dnum[2*W-2:0], dge};
        drem_next = dge ? W'(dtrial - {1'b0, dden}) : dtrial[W-1:0];
        dcnt_next = dcnt + DCW'(1);
      end

      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pfau_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = pfau_pkg::ST_STEP;
        end
      end
      pfau_pkg::ST_STEP: begin
        unique case (act)
          pfau_pkg::ACT_MUL:  state_next = pfau_pkg::ST_MUL;
          pfau_pkg::ACT_DIV:  state_next = pfau_pkg::ST_DIV;
          pfau_pkg::ACT_DONE: state_next = pfau_pkg::ST_IDLE;
          default:            state_next = pfau_pkg::ST_STEP;
        endcase
      end
      pfau_pkg::ST_MUL: begin
        state_next = pfau_pkg::ST_DIV;
      end
      pfau_pkg::ST_DIV: begin
        if (dcnt == DCW'(2 * W - 1)) begin
          state_next = pfau_pkg::ST_STEP;
        end
      end
      default: begin
        state_next = pfau_pkg::ST_IDLE;
      end
    endcase
  end

  // handshake outputs
  always_comb begin
    req.ready        = (state == pfau_pkg::ST_IDLE);
    rsp.valid        = out_valid;
    rsp.result_value = res_q;
    rsp.signed_value = sres_q;
    rsp.error_flag   = err_q;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfau_pkg::ST_IDLE;
      pc        <= pfau_pkg::PC_0;
      out_valid <= 1'b0;
      prime     <= DB'(2);
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        prime <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op     <= op_next;
    a      <= a_next;
    b      <= b_next;
    c      <= c_next;
    d      <= d_next;
    x      <= x_next;
    acc    <= acc_next;
    n      <= n_next;
    r0     <= r0_next;
    r1     <= r1_next;
    t0     <= t0_next;
    t1     <= t1_next;
    cnt    <= cnt_next;
    mx     <= mx_next;
    my     <= my_next;
    dnum   <= dnum_next;
    drem   <= drem_next;
    dden   <= dden_next;
    dcnt   <= dcnt_next;
    res_q  <= res_next;
    sres_q <= sres_next;
    err_q  <= err_next;
  end

endmodule
